// File: rtl/core/pareto_front_mask_2d_macros.svh
// assertion macros used by the pareto front top level
`ifndef PARETO_FRONT_MASK_2D_MACROS_SVH
`define PARETO_FRONT_MASK_2D_MACROS_SVH

// same-cycle implication, checked on the rising edge of clock outside reset
`define PFM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on the rising edge of clock outside reset
`define PFM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/pfm2d_pkg.sv
// types, constants and the dominance test for the pareto front marker
package pfm2d_pkg;

   localparam int VALUE_W       = 32;
   localparam int POINT_INDEX_W = 6;

   // point travelling down the cell chain
   typedef struct packed {
      logic                      valid;
      logic                      hit;
      logic signed [VALUE_W-1:0] cost;
      logic signed [VALUE_W-1:0] gain;
   } beat_type;

   // per-cell flags handed toward the head during the result run
   typedef struct packed {
      logic valid;
      logic dominated;
   } flag_type;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_DRAIN,
      ST_REPORT
   } state_type;

   // point a dominates point b: cost minimized, gain maximized
   function automatic logic dominates(
      input logic signed [VALUE_W-1:0] cost_a,
      input logic signed [VALUE_W-1:0] gain_a,
      input logic signed [VALUE_W-1:0] cost_b,
      input logic signed [VALUE_W-1:0] gain_b
   );
      return (cost_a <= cost_b) && (gain_a >= gain_b) &&
             ((cost_a < cost_b) || (gain_a > gain_b));
   endfunction

endpackage

// File: rtl/core/pfm2d_cell.sv
// one storage cell of the chain: holds a point, compares the passing beat
module pfm2d_cell
   import pfm2d_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     shift,
   input  beat_type beat_prev,
   output beat_type beat_next,
   input  flag_type flag_from_next,
   output flag_type flag_out
);

   logic                      valid_ff, valid_in;
   logic                      dom_ff, dom_in;
   logic signed [VALUE_W-1:0] cost_ff, cost_in;
   logic signed [VALUE_W-1:0] gain_ff, gain_in;
   logic                      beat_valid_ff;
   logic                      beat_hit_ff;
   logic signed [VALUE_W-1:0] beat_cost_ff;
   logic signed [VALUE_W-1:0] beat_gain_ff;
   beat_type                  beat_in;
   logic                      beat_wins;
   logic                      stored_wins;

   // compare the arriving beat against the held point
   assign beat_wins   = dominates(beat_prev.cost, beat_prev.gain, cost_ff, gain_ff);
   assign stored_wins = dominates(cost_ff, gain_ff, beat_prev.cost, beat_prev.gain);

   // next state: shift toward the head, or compare / capture
   always_comb begin
      valid_in      = valid_ff;
      dom_in        = dom_ff;
      cost_in       = cost_ff;
      gain_in       = gain_ff;
      beat_in       = beat_prev;
      beat_in.valid = 1'b0;
      if (shift) begin
         valid_in = flag_from_next.valid;
         dom_in   = flag_from_next.dominated;
      end else if (beat_prev.valid) begin
         if (valid_ff) begin
            // held point stays, beat moves on carrying its hit
            dom_in        = dom_ff | beat_wins;
            beat_in.valid = 1'b1;
            beat_in.hit   = beat_prev.hit | stored_wins;
         end else begin
            // first empty cell captures the beat
            valid_in = 1'b1;
            dom_in   = beat_prev.hit;
            cost_in  = beat_prev.cost;
            gain_in  = beat_prev.gain;
         end
      end
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         dom_ff        <= 1'b0;
         beat_valid_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         dom_ff        <= dom_in;
         beat_valid_ff <= beat_in.valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cost_ff      <= cost_in;
      gain_ff      <= gain_in;
      beat_hit_ff  <= beat_in.hit;
      beat_cost_ff <= beat_in.cost;
      beat_gain_ff <= beat_in.gain;
   end

   assign beat_next = '{valid: beat_valid_ff, hit: beat_hit_ff, cost: beat_cost_ff,
                        gain: beat_gain_ff};
   assign flag_out  = '{valid: valid_ff, dominated: dom_ff};

endmodule

// File: rtl/core/pareto_front_mask_2d.sv
// Pareto front marker for two-criteria points, top level
//
// Usage: present a point on req_cost_value / req_gain_value and pulse start
// while busy is low; the beat is taken on that edge. Points may come every
// cycle while busy is low. Cost is minimized, gain maximized, both signed Q16.16.
// Each point walks down a chain of MAX_POINTS cells, one cell per cycle,
// comparing with every held point on the way and landing in the first
// empty cell. Points beyond MAX_POINTS are dropped and flagged as overflow.
// When the beat with req_is_final_point high is taken, busy rises: the chain
// drains, then one result per stored point leaves on rsp_* marked by
// rsp_strobe, one per cycle, in arrival order, with rsp_run_end on the last.
// The flags shift toward the chain head during the run, which also empties
// the chain. busy falls after the last result.
// The receiver cannot stall; results must be taken as they appear.
// Synchronous reset empties the chain and returns to accepting points.
module pareto_front_mask_2d
   import pfm2d_pkg::*;
#(
   parameter int MAX_POINTS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic signed [VALUE_W-1:0]       req_cost_value,
   input  logic signed [VALUE_W-1:0]       req_gain_value,
   input  logic                            req_is_final_point,
   output logic                            rsp_strobe,
   output logic        [POINT_INDEX_W-1:0] rsp_point_index,
   output logic                            rsp_on_front,
   output logic                            rsp_run_end,
   output logic                            rsp_overflowed
);

`include "pareto_front_mask_2d_macros.svh"

   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int DRAIN_LAST = MAX_POINTS - 2;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [IDX_W-1:0]   drain_ff, drain_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               accept;
   logic               inject;
   logic               shift;
   logic               last_result;
   beat_type           beats [MAX_POINTS+1];
   flag_type           flags [MAX_POINTS+1];

   assign accept      = start && !busy;
   assign inject      = accept && (count_ff != CNT_W'(MAX_POINTS));
   assign shift       = (state_ff == ST_REPORT);
   assign last_result = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;

   // head of the chain takes the accepted point straight from the ports
   assign beats[0] = '{valid: inject, hit: 1'b0, cost: req_cost_value,
                       gain: req_gain_value};
   assign flags[MAX_POINTS] = '0;

   // the cell chain
   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      pfm2d_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .shift          (shift),
         .beat_prev      (beats[i]),
         .beat_next      (beats[i+1]),
         .flag_from_next (flags[i+1]),
         .flag_out       (flags[i])
      );
   end

   // sequencer: collect, drain, report
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      drain_in = drain_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_COLLECT: begin
            drain_in = '0;
            idx_in   = '0;
            if (accept) begin
               if (inject) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_is_final_point) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + IDX_W'(1);
            if (drain_ff == IDX_W'(DRAIN_LAST)) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            idx_in = idx_ff + IDX_W'(1);
            if (last_result) begin
               state_in = ST_COLLECT;
               count_in = '0;
               ovf_in   = 1'b0;
               idx_in   = '0;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         drain_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         drain_ff <= drain_in;
         idx_ff   <= idx_in;
      end
   end

   // outputs: result comes from the chain head
   assign busy            = (state_ff != ST_COLLECT);
   assign rsp_strobe      = shift;
   assign rsp_point_index = POINT_INDEX_W'(idx_ff);
   assign rsp_on_front    = !flags[0].dominated;
   assign rsp_run_end     = shift && last_result;
   assign rsp_overflowed  = ovf_ff;

   // no beat ever runs off the end of the chain
   `PFM_ASSERT_NOW(a_tail_empty, 1'b1, !beats[MAX_POINTS].valid, "beat left the chain")
   // every reported entry is a stored point
   `PFM_ASSERT_NOW(a_head_valid, rsp_strobe, flags[0].valid, "result from empty cell")
   // the run ends with the chain emptied and accepting again
   `PFM_ASSERT_NEXT(a_run_done, rsp_strobe && rsp_run_end,
      !busy && (count_ff == '0) && !flags[0].valid, "chain not cleared after run")
   // a final beat always starts the drain
   `PFM_ASSERT_NEXT(a_final_busy, accept && req_is_final_point,
      state_ff == ST_DRAIN, "final point did not start drain")

endmodule
